// ===== src/m4vt_pkg.sv =====
package m4vt_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned N_DIM    = 4;
    localparam int unsigned N_REGS   = 8;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned PROD_W   = 2 * DATA_W;
    localparam int unsigned PAIR_W   = PROD_W + 1;
    localparam int unsigned SUM_W    = PROD_W + 2;
    localparam int unsigned VEC_W    = N_DIM * DATA_W;
    localparam int unsigned N_STAGES = 4;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [ADDR_W-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5,
        REG_ROW3_COLS01 = 3'd6,
        REG_ROW3_COLS23 = 3'd7
    } m4vt_reg_t;

    // Reset values give the identity matrix; element 0 is register 0.
    localparam logic [N_REGS-1:0][CFG_W-1:0] CFG_RESET = {
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef logic [N_DIM-1:0][DATA_W-1:0] m4vt_vec_t;
    typedef logic [N_DIM-1:0][N_DIM-1:0][DATA_W-1:0] m4vt_mat_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic mul;
        logic add1;
        logic add2;
        logic sat;
    } m4vt_adv_t;

endpackage

// ===== src/m4vt_regs.sv =====
module m4vt_regs
    import m4vt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output m4vt_mat_t         mat
);

    logic [N_REGS-1:0][CFG_W-1:0] regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Each register holds two entries of a row: even column low, odd column high.
    always_comb
    begin
        for (int r = 0; r < N_DIM; r++)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                mat[r][c] = regs_reg[r * 2 + c / 2][(c % 2) * DATA_W +: DATA_W];
            end
        end
    end

endmodule

// ===== src/m4vt_row.sv =====
module m4vt_row
    import m4vt_pkg::*;
(
    input  logic              clk,
    input  m4vt_adv_t         adv,
    input  m4vt_vec_t         row,
    input  m4vt_vec_t         vec,
    output logic [DATA_W-1:0] result
);

    logic signed [PROD_W-1:0] prod_reg [N_DIM];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [SUM_W-1:0]  sum_reg;
    logic [DATA_W-1:0]        result_reg;
    logic [DATA_W-1:0]        result_next;
    logic [SUM_W-DATA_W-FRAC_W:0] top_bits;

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            for (int c = 0; c < N_DIM; c++)
            begin
                prod_reg[c] <= $signed(row[c]) * $signed(vec[c]);
            end
        end
        if (adv.add1)
        begin
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
        end
        if (adv.add2)
        begin
            sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        end
        if (adv.sat)
        begin
            result_reg <= result_next;
        end
    end

    // The shifted sum fits in 32 bits only when all bits above bit 46 agree.
    assign top_bits = sum_reg[SUM_W-1:DATA_W+FRAC_W-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            result_next = sum_reg[DATA_W+FRAC_W-1:FRAC_W];
        end
        else if (sum_reg[SUM_W-1])
        begin
            result_next = SAT_MIN;
        end
        else
        begin
            result_next = SAT_MAX;
        end
    end

    assign result = result_reg;

endmodule

// ===== src/matrix4_vector_transform.sv =====
// Channel   Direction  Width  Contents (lowest bits first)
// s_*       in         128    x, y, z, w: signed Q16.16 vector
// m_*       out        128    x, y, z, w: saturated signed Q16.16 result
// cfg_*     in         64     matrix registers 0..7, two entries each
//
// One vector per cycle while the output is not stalled; after its transfer a vector passes
// through the multiply, two adder levels, then shift and saturate into the output register.
// Reset restores the identity matrix and empties the pipeline.
// Each stage holds its item while the next is full and stalled, so bubbles close
// up and inputs are still taken while a finished result waits.
module matrix4_vector_transform
    import m4vt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [VEC_W-1:0]  s_tdata,   // in_x, in_y, in_z, in_w
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [VEC_W-1:0]  m_tdata,   // out_x, out_y, out_z, out_w
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    m4vt_mat_t                mat;
    m4vt_vec_t                vec;
    m4vt_adv_t                adv;
    logic [N_STAGES-1:0]      valid_reg;
    logic [N_STAGES-1:0]      valid_next;

    m4vt_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .mat       (mat)
    );

    assign vec = s_tdata;

    // Stage 3 is the output register.
    always_comb
    begin
        adv.sat  = !valid_reg[3] || m_tready;
        adv.add2 = !valid_reg[2] || adv.sat;
        adv.add1 = !valid_reg[1] || adv.add2;
        adv.mul  = !valid_reg[0] || adv.add1;

        valid_next[0] = adv.mul  ? s_tvalid     : valid_reg[0];
        valid_next[1] = adv.add1 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = adv.add2 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = adv.sat  ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar r = 0; r < N_DIM; r++)
    begin : g_row
        m4vt_row u_row (
            .clk    (clk),
            .adv    (adv),
            .row    (mat[r]),
            .vec    (vec),
            .result (m_tdata[r*DATA_W +: DATA_W])
        );
    end

    assign s_tready = adv.mul;
    assign m_tvalid = valid_reg[3];

endmodule

// ===== src/m4vt_checker.sv =====
module m4vt_checker
    import m4vt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [VEC_W-1:0]  m_tdata
);

    // A result that is not taken stays on the bus unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // With the output free or taken, nothing upstream can be blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although output is free");

    // While the output stays ready, each transfer is matched by a result once it has passed every stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
         && $past(rst_n, 5) && $past(m_tready, 1) && $past(m_tready, 2)
         && $past(m_tready, 3) && $past(m_tready, 4))
        |-> (m_tvalid == $past(s_tvalid && s_tready, 4)))
        else $error("pipeline latency mismatch");

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ===== dv/testbench.sv =====
module testbench;
    import m4vt_pkg::*;

    localparam logic [DATA_W-1:0] ONE_Q        = 32'h0001_0000;
    localparam logic [DATA_W-1:0] MINUS_ONE_Q  = 32'hFFFF_0000;
    localparam int                LIMIT_CYCLES = 500000;
    localparam int                MAX_PRINTED  = 200;

    typedef enum int {
        MIX_FULL,
        MIX_NEAR_UNIT,
        MIX_EXTREME
    } value_mix_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [VEC_W-1:0]  s_tdata;   // in_x, in_y, in_z, in_w
    logic              m_tvalid;
    logic              m_tready;
    logic [VEC_W-1:0]  m_tdata;   // out_x, out_y, out_z, out_w
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    m4vt_mat_t  matrix_shadow;
    m4vt_vec_t  results_due[$];
    m4vt_vec_t  oldest_result;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         idle_on;
    int         hold_cycles;
    int         ready_stall_left = 0;
    string      field_name[N_DIM] = '{"out_x", "out_y", "out_z", "out_w"};

    matrix4_vector_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Exact sum of four Q32.32 products, floored to Q16.16 and saturated.
    function automatic m4vt_vec_t transform_vector(input m4vt_vec_t v);
        m4vt_vec_t          res;
        logic signed [63:0] prod;
        logic signed [65:0] acc;
        logic signed [65:0] shifted;
        for (int r = 0; r < N_DIM; r++)
        begin
            acc = '0;
            for (int c = 0; c < N_DIM; c++)
            begin
                prod = $signed(matrix_shadow[r][c]) * $signed(v[c]);
                acc  = acc + prod;
            end
            shifted = acc >>> FRAC_W;
            if (shifted[65:31] == '0 || shifted[65:31] == '1)
                res[r] = shifted[31:0];
            else if (shifted[65])
                res[r] = SAT_MIN;
            else
                res[r] = SAT_MAX;
        end
        return res;
    endfunction

    function automatic m4vt_vec_t make_vec(input logic [DATA_W-1:0] x,
                                           input logic [DATA_W-1:0] y,
                                           input logic [DATA_W-1:0] z,
                                           input logic [DATA_W-1:0] w);
        m4vt_vec_t v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = w;
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] random_word(input value_mix_t mix);
        logic [DATA_W-1:0] w;
        case (mix)
            MIX_FULL:
                w = $urandom();
            MIX_NEAR_UNIT:
            begin
                // Roughly -4.0 to +4.0, so sums rarely saturate.
                w = $urandom_range(0, 32'h7FFFF);
                w = w - 32'h40000;
            end
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       w = SAT_MAX;
                    1:       w = SAT_MIN;
                    2:       w = '0;
                    3:       w = ONE_Q;
                    4:       w = MINUS_ONE_Q;
                    5:       w = 32'h0000_0001;
                    default: w = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        return w;
    endfunction

    function automatic m4vt_vec_t random_vector();
        m4vt_vec_t  v;
        value_mix_t mix;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            mix = MIX_NEAR_UNIT;
        else if (pick < 8)
            mix = MIX_FULL;
        else
            mix = MIX_EXTREME;
        for (int c = 0; c < N_DIM; c++)
            v[c] = random_word(mix);
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch %s: got %h expected %h at cycle %0d",
                     what, got, want, cycle_count);
        mismatch_count++;
    endtask

    task automatic write_reg(input m4vt_reg_t r, input logic [CFG_W-1:0] val);
        int row;
        int col;
        row = int'(r) / 2;
        col = (int'(r) % 2) * 2;
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = r;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        matrix_shadow[row][col]     = val[31:0];
        matrix_shadow[row][col + 1] = val[63:32];
    endtask

    // With partial set, each register is written or skipped at random.
    task automatic load_matrix(input m4vt_mat_t m, input bit partial);
        m4vt_reg_t r;
        int        row;
        int        col;
        r = r.first();
        do
        begin
            row = int'(r) / 2;
            col = (int'(r) % 2) * 2;
            if (!partial || $urandom_range(0, 1) == 1)
                write_reg(r, {m[row][col + 1], m[row][col]});
            r = r.next();
        end
        while (r != r.first());
    endtask

    task automatic push_vector(input m4vt_vec_t v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = v;
        do
            @(posedge clk);
        while (!s_tready);
        results_due.push_back(transform_vector(v));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // The reset matrix is the identity, so every vector comes back unchanged.
    task automatic test_reset_identity();
        push_vector(make_vec('0, '0, '0, '0));
        push_vector(make_vec(SAT_MAX, SAT_MIN, 32'h0000_0001, 32'hFFFF_FFFF));
        push_vector(make_vec(SAT_MIN, SAT_MAX, 32'hFFFF_FFFF, 32'h0000_0001));
        push_vector(make_vec(32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_5555, 32'hAAAA_AAAA));
        wait_drained();
    endtask

    task automatic test_saturation_rounding();
        m4vt_mat_t m;
        m = '0;
        m[0][0] = ONE_Q;
        m[0][1] = ONE_Q;
        for (int c = 0; c < N_DIM; c++)
        begin
            m[1][c] = SAT_MAX;
            m[2][c] = SAT_MIN;
        end
        m[3][0] = 32'h0000_0001;
        load_matrix(m, 1'b0);
        // Row 0 sits on both edges of the range and one step past each.
        push_vector(make_vec(SAT_MAX, '0, '0, '0));
        push_vector(make_vec(SAT_MAX, 32'h0000_0001, '0, '0));
        push_vector(make_vec(SAT_MIN, '0, '0, '0));
        push_vector(make_vec(SAT_MIN, 32'hFFFF_FFFF, '0, '0));
        // Rows 1 and 2 saturate the result in both directions.
        push_vector(make_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
        push_vector(make_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        // Row 3 shows the shift flooring negative values.
        push_vector(make_vec(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
        push_vector(make_vec(32'h0000_FFFF, '0, '0, '0));
        push_vector(make_vec(32'hFFFE_FFFF, '0, '0, '0));
        push_vector(make_vec(ONE_Q, '0, '0, '0));
        wait_drained();
    endtask

    task automatic test_single_register();
        write_reg(REG_ROW3_COLS23, {SAT_MIN, ONE_Q});
        push_vector(make_vec('0, '0, ONE_Q, '0));
        push_vector(make_vec('0, '0, '0, MINUS_ONE_Q));
        push_vector(make_vec(ONE_Q, MINUS_ONE_Q, ONE_Q, ONE_Q));
        wait_drained();
    endtask

    task automatic test_random_phases(input int n_phases, input int per_phase);
        m4vt_mat_t  m;
        value_mix_t mix;
        for (int p = 0; p < n_phases; p++)
        begin
            wait_drained();
            case (p % 3)
                0:       mix = MIX_NEAR_UNIT;
                1:       mix = MIX_FULL;
                default: mix = MIX_EXTREME;
            endcase
            for (int r = 0; r < N_DIM; r++)
                for (int c = 0; c < N_DIM; c++)
                    m[r][c] = random_word(mix);
            load_matrix(m, $urandom_range(0, 2) == 0);
            for (int i = 0; i < per_phase; i++)
                push_vector(random_vector());
        end
        wait_drained();
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        hold_cycles = 80;
        for (int i = 0; i < 30; i++)
            push_vector(random_vector());
        wait_drained();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        for (int i = 0; i < 120; i++)
            push_vector(random_vector());
        wait_drained();
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready = 1'b0;
                hold_cycles--;
            end
            else if (ready_stall_left > 0)
            begin
                m_tready = 1'b0;
                ready_stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready         = 1'b0;
                ready_stall_left = $urandom_range(1, 6) - 1;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch("result with no vector pending", m_tdata[31:0], '0);
            end
            else
            begin
                oldest_result = results_due.pop_front();
                for (int c = 0; c < N_DIM; c++)
                    if (m_tdata[c * DATA_W +: DATA_W] !== oldest_result[c])
                        report_mismatch(field_name[c], m_tdata[c * DATA_W +: DATA_W],
                                        oldest_result[c]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL matrix4_vector_transform");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        cfg_we           = 1'b0;
        cfg_addr         = REG_ROW0_COLS01;
        cfg_wdata        = '0;
        idle_on          = 1'b1;
        hold_cycles      = 0;
        for (int r = 0; r < N_DIM; r++)
            for (int c = 0; c < N_DIM; c++)
                matrix_shadow[r][c] = (r == c) ? ONE_Q : '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_identity();
        test_saturation_rounding();
        test_single_register();
        test_random_phases(10, 120);
        test_backpressure();
        test_full_rate();

        repeat (2 * N_STAGES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS matrix4_vector_transform");
        else
            $display("FAIL matrix4_vector_transform");
        $finish;
    end

endmodule
